>>> hdl/tetb_pkg.sv
// shared constants, types and command struct for the timer bank
package tetb_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W       = $clog2(TIMER_COUNT + 1);

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_ENABLE  = 2'd1,
        OP_DISABLE = 2'd2
    } tetb_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } tetb_state_t;

    typedef struct packed {
        logic             load;
        logic             clear;
        logic             step;
        logic             flush;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] widx;
    } tetb_cmd_t;

endpackage

>>> hdl/tetb_ctrl.sv
// controller: request decode, walk sequencing and walk length register
module tetb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          opcode,
    input  logic [2:0]          timer_index,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_wr_data,
    output logic                busy,
    output tetb_pkg::tetb_cmd_t cmd
);
    import tetb_pkg::*;

    tetb_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [3:0]       tiu_reg;
    logic [7:0]       tiu8;
    logic [CNT_W-1:0] walk_len;
    logic             idx_ok;

    assign tiu8     = 8'(tiu_reg);
    assign walk_len = (tiu8 > 8'(TIMER_COUNT)) ? CNT_W'(TIMER_COUNT) : CNT_W'(tiu8);
    assign idx_ok   = 8'(timer_index) < 8'(TIMER_COUNT);
    assign busy     = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            len_reg   <= '0;
            tiu_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            if (cfg_wr_en)
            begin
                tiu_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.widx   = IDX_W'(timer_index);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (tetb_op_t'(opcode))
                        OP_ENABLE:  cmd.load  = idx_ok;
                        OP_DISABLE: cmd.clear = idx_ok;
                        OP_TICK:
                        begin
                            if (walk_len != '0)
                            begin
                                state_next = ST_WALK;
                                idx_next   = '0;
                                len_next   = walk_len;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (CNT_W'(idx_reg) + CNT_W'(1) == len_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    idx_next = IDX_W'(idx_reg + 1'b1);
                end
            end
            ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load || cmd.clear) |-> (state_reg == ST_IDLE && !cmd.step))
        else $error("timer write outside idle");
    a_flush_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |=> (state_reg == ST_IDLE))
        else $error("flush did not return to idle");
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (CNT_W'(idx_reg) < len_reg))
        else $error("walk index past walk length");
`endif

endmodule

>>> hdl/tetb_datapath.sv
// datapath: timer counts, reload values, pending expiry and result register
module tetb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tetb_pkg::tetb_cmd_t cmd,
    input  logic [15:0]         load_count,
    input  logic [15:0]         reload_interval,
    output logic                result_valid,
    output logic [2:0]          expired_timer,
    output logic                last
);
    import tetb_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg  [TIMER_COUNT];
    logic [COUNT_WIDTH-1:0] count_next [TIMER_COUNT];
    logic [COUNT_WIDTH-1:0] reload_reg  [TIMER_COUNT];
    logic [COUNT_WIDTH-1:0] reload_next [TIMER_COUNT];
    logic [COUNT_WIDTH-1:0] cur;
    logic                   fire;
    logic                   pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                   valid_reg, valid_next;
    logic [2:0]             expired_reg, expired_next;
    logic                   last_reg, last_next;

    assign cur  = count_reg[cmd.idx];
    assign fire = cmd.step && (cur == COUNT_WIDTH'(1));

    always_comb
    begin
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            count_next[i]  = count_reg[i];
            reload_next[i] = reload_reg[i];
        end
        if (cmd.load)
        begin
            count_next[cmd.widx]  = COUNT_WIDTH'(load_count);
            reload_next[cmd.widx] = COUNT_WIDTH'(reload_interval);
        end
        else if (cmd.clear)
        begin
            count_next[cmd.widx]  = '0;
            reload_next[cmd.widx] = '0;
        end
        else if (cmd.step && cur != '0)
        begin
            count_next[cmd.idx] = fire ? reload_reg[cmd.idx] : cur - COUNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        valid_next      = 1'b0;
        expired_next    = expired_reg;
        last_next       = last_reg;
        if (fire)
        begin
            if (pend_valid_reg)
            begin
                valid_next   = 1'b1;
                expired_next = 3'(pend_idx_reg);
                last_next    = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_idx_next   = cmd.idx;
        end
        else if (cmd.flush)
        begin
            if (pend_valid_reg)
            begin
                valid_next   = 1'b1;
                expired_next = 3'(pend_idx_reg);
                last_next    = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                count_reg[i]  <= '0;
                reload_reg[i] <= '0;
            end
            pend_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < TIMER_COUNT; i++)
            begin
                count_reg[i]  <= count_next[i];
                reload_reg[i] <= reload_next[i];
            end
            pend_valid_reg <= pend_valid_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        expired_reg  <= expired_next;
        last_reg     <= last_next;
    end

    assign result_valid  = valid_reg;
    assign expired_timer = expired_reg;
    assign last          = last_reg;

`ifndef NO_ASSERTIONS
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> !pend_valid_reg)
        else $error("pending expiry left after flush");
    a_empty_flush_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.flush && !pend_valid_reg) |=> !result_valid)
        else $error("result from empty flush");
    a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> $past(cmd.flush))
        else $error("last marker without flush");
`endif

endmodule

>>> hdl/time_event_timer_bank.sv
// top level of the time-event timer bank
// enable, disable, unused and zero-length tick requests leave busy low
// a tick request walks min(timers_in_use, 8) timers, one per cycle, then a flush
// step; busy is high during walk and flush, and the next request follows right after
// an expiry is held until the next expiry of the walk or the flush and shows on
// result_valid in the cycle after; the receiver cannot stall, a result lasts one cycle
// asynchronous active-low reset clears all counts, reloads and timers_in_use
module time_event_timer_bank (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [2:0]  timer_index,
    input  logic [15:0] load_count,
    input  logic [15:0] reload_interval,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    output logic        result_valid,
    output logic [2:0]  expired_timer,
    output logic        last
);
    import tetb_pkg::*;

    tetb_cmd_t cmd;

    tetb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .timer_index (timer_index),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .busy        (busy),
        .cmd         (cmd)
    );

    tetb_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .load_count      (load_count),
        .reload_interval (reload_interval),
        .result_valid    (result_valid),
        .expired_timer   (expired_timer),
        .last            (last)
    );

endmodule

>>> bench/time_event_timer_bank_test.sv
// self-checking testbench for the time-event timer bank
`timescale 1ns / 1ps

module time_event_timer_bank_test;

    import tetb_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         SETTLE_CYC  = 12;
    localparam int         STALL_LIMIT = 1000;
    localparam int         PLAN_LEN    = 24;
    localparam int         PHASE_ITEMS = 80;

    typedef struct {
        logic [2:0] timer;
        logic       last;
    } expiry_t;

    typedef struct {
        bit          is_cfg;
        logic [3:0]  cfg_val;
        logic [1:0]  op;
        logic [2:0]  idx;
        logic [15:0] ld;
        logic [15:0] rl;
        bit          typed;
        int          tcnt;
        logic [2:0]  ttimer;
    } plan_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  opcode = OP_TICK;
    logic [2:0]  timer_index = 3'd0;
    logic [15:0] load_count = 16'd0;
    logic [15:0] reload_interval = 16'd0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = 4'd0;
    logic        result_valid;
    logic [2:0]  expired_timer;
    logic        last;

    // timer bank mirror
    logic [15:0] remaining [TIMER_COUNT];
    logic [15:0] reload    [TIMER_COUNT];
    int          walk_len;

    expiry_t     expiry_q [$];
    expiry_t     fresh_expiries [$];
    expiry_t     got;

    int          idle_pct;
    int          mismatches;
    int          stall_cycles = 0;
    int          n_requests;
    int          n_ticks;
    int          n_checked;

    plan_row_t plan [PLAN_LEN] = '{
        '{0, 4'd0,  OP_TICK,    3'd0, 16'd0,     16'd0,     1, 0, 3'd0},
        '{0, 4'd0,  OP_ENABLE,  3'd0, 16'd1,     16'd0,     1, 0, 3'd0},
        '{0, 4'd0,  OP_TICK,    3'd7, 16'hffff,  16'hffff,  1, 0, 3'd0},
        '{1, 4'd8,  OP_TICK,    3'd0, 16'd0,     16'd0,     0, 0, 3'd0},
        '{0, 4'd0,  OP_TICK,    3'd0, 16'd0,     16'd0,     1, 1, 3'd0},
        '{0, 4'd0,  OP_TICK,    3'd0, 16'd0,     16'd0,     1, 0, 3'd0},
        '{0, 4'd0,  OP_ENABLE,  3'd7, 16'hffff,  16'hffff,  1, 0, 3'd0},
        '{0, 4'd0,  OP_ENABLE,  3'd3, 16'd2,     16'd1,     1, 0, 3'd0},
        '{0, 4'd0,  OP_ENABLE,  3'd5, 16'd1,     16'd2,     1, 0, 3'd0},
        '{0, 4'd0,  OP_TICK,    3'd0, 16'd0,     16'd0,     0, 0, 3'd0},
        '{0, 4'd0,  OP_TICK,    3'd2, 16'h5a5a,  16'ha5a5,  0, 0, 3'd0},
        '{0, 4'd0,  OP_UNUSED,  3'd7, 16'hffff,  16'hffff,  1, 0, 3'd0},
        '{0, 4'd0,  OP_ENABLE,  3'd6, 16'd0,     16'd4,     1, 0, 3'd0},
        '{0, 4'd0,  OP_TICK,    3'd0, 16'd0,     16'd0,     0, 0, 3'd0},
        '{0, 4'd0,  OP_DISABLE, 3'd3, 16'hffff,  16'hffff,  1, 0, 3'd0},
        '{1, 4'd15, OP_TICK,    3'd0, 16'd0,     16'd0,     0, 0, 3'd0},
        '{0, 4'd0,  OP_TICK,    3'd0, 16'd0,     16'd0,     0, 0, 3'd0},
        '{1, 4'd3,  OP_TICK,    3'd0, 16'd0,     16'd0,     0, 0, 3'd0},
        '{0, 4'd0,  OP_ENABLE,  3'd1, 16'd1,     16'd3,     1, 0, 3'd0},
        '{0, 4'd0,  OP_ENABLE,  3'd2, 16'd1,     16'd3,     1, 0, 3'd0},
        '{0, 4'd0,  OP_TICK,    3'd0, 16'd0,     16'd0,     0, 0, 3'd0},
        '{1, 4'd0,  OP_TICK,    3'd0, 16'd0,     16'd0,     0, 0, 3'd0},
        '{0, 4'd0,  OP_TICK,    3'd0, 16'd0,     16'd0,     1, 0, 3'd0},
        '{1, 4'd8,  OP_TICK,    3'd0, 16'd0,     16'd0,     0, 0, 3'd0}
    };

    time_event_timer_bank dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .timer_index     (timer_index),
        .load_count      (load_count),
        .reload_interval (reload_interval),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .result_valid    (result_valid),
        .expired_timer   (expired_timer),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void predict_request(logic [1:0] op, logic [2:0] idx,
                                            logic [15:0] ld, logic [15:0] rl);
        int n_walk;
        fresh_expiries.delete();
        case (op)
            OP_ENABLE:
            begin
                remaining[idx] = ld;
                reload[idx]    = rl;
            end
            OP_DISABLE:
            begin
                remaining[idx] = '0;
                reload[idx]    = '0;
            end
            OP_TICK:
            begin
                n_walk = (walk_len > TIMER_COUNT) ? TIMER_COUNT : walk_len;
                for (int i = 0; i < n_walk; i++)
                begin
                    if (remaining[i] != 16'd0)
                    begin
                        remaining[i] = remaining[i] - 16'd1;
                        if (remaining[i] == 16'd0)
                        begin
                            remaining[i] = reload[i];
                            fresh_expiries.push_back('{i[2:0], 1'b0});
                        end
                    end
                end
                if (fresh_expiries.size() > 0)
                    fresh_expiries[fresh_expiries.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(string what, int expv, int actv);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, expv, actv);
    endtask

    task automatic send_request(logic [1:0] op, logic [2:0] idx, logic [15:0] ld,
                                logic [15:0] rl, bit typed, int tcnt, logic [2:0] ttimer);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start           <= 1'b1;
        opcode          <= op;
        timer_index     <= idx;
        load_count      <= ld;
        reload_interval <= rl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(op, idx, ld, rl);
        n_requests++;
        if (op == OP_TICK)
            n_ticks++;
        if (typed)
        begin
            if (tcnt > 0)
                expiry_q.push_back('{ttimer, 1'b1});
        end
        else
        begin
            foreach (fresh_expiries[i])
                expiry_q.push_back(fresh_expiries[i]);
        end
    endtask

    task automatic drain_bank;
        start <= 1'b0;
        while (expiry_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_walk(logic [3:0] value);
        drain_bank();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        walk_len = int'(value);
    endtask

    task automatic send_random_request;
        int          r;
        logic [1:0]  op;
        logic [2:0]  idx;
        logic [15:0] ld;
        logic [15:0] rl;
        r   = int'($urandom_range(99));
        idx = 3'($urandom_range(7));
        ld  = 16'($urandom_range(16'hffff));
        rl  = 16'($urandom_range(16'hffff));
        if (r < 45)
            op = OP_TICK;
        else if (r < 75)
        begin
            op = OP_ENABLE;
            ld = 16'($urandom_range(1, 6));
            rl = 16'($urandom_range(0, 5));
        end
        else if (r < 80)
            op = OP_ENABLE;
        else if (r < 85)
        begin
            op = OP_ENABLE;
            ld = 16'd0;
        end
        else if (r < 95)
            op = OP_DISABLE;
        else
            op = OP_UNUSED;
        send_request(op, idx, ld, rl, 0, 0, 3'd0);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expiry_q.size() == 0)
                note_mismatch("unexpected expiry, timer", -1, int'(expired_timer));
            else
            begin
                got = expiry_q.pop_front();
                n_checked++;
                if (expired_timer !== got.timer)
                    note_mismatch("expired_timer", int'(got.timer), int'(expired_timer));
                if (last !== got.last)
                    note_mismatch("last", int'(got.last), int'(last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            remaining[i] = '0;
            reload[i]    = '0;
        end
        walk_len     = 0;
        idle_pct     = 0;
        mismatches   = 0;
        n_requests   = 0;
        n_ticks      = 0;
        n_checked    = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_walk(plan[i].cfg_val);
            else
                send_request(plan[i].op, plan[i].idx, plan[i].ld, plan[i].rl,
                             plan[i].typed, plan[i].tcnt, plan[i].ttimer);
        end

        for (int p = 0; p < 3; p++)
        begin
            idle_pct = (p == 0) ? 10 : (p == 1) ? 76 : 0;
            if (p == 0)
                write_walk(4'd8);
            else if (p == 1)
                write_walk(4'($urandom_range(1, 15)));
            else
                write_walk(4'($urandom_range(5, 8)));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 1 && k == 40)
                    drain_bank();
                send_random_request();
            end
        end

        drain_bank();
        if (expiry_q.size() != 0)
            note_mismatch("expiries left over", 0, expiry_q.size());

        $display("ran %0d requests with %0d ticks over walk lengths 0 to 15", n_requests,
                 n_ticks);
        $display("checked %0d expiries, %0d mismatches", n_checked, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
hdl/tetb_pkg.sv
hdl/tetb_ctrl.sv
hdl/tetb_datapath.sv
hdl/time_event_timer_bank.sv
bench/time_event_timer_bank_test.sv
